// ----- sv/gpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_pkg: shared types, constants and tables
// Calendar codes, epoch constants, reciprocal constants and month tables
// used by the Gregorian/Persian date converter.
// ----------------------------------------------------------------------------
package gpd_pkg;

	typedef enum logic {
		CAL_GREG = 1'b0,
		CAL_PERS = 1'b1
	} cal_t;

	localparam int YEAR_W = 12;
	localparam int JD_W   = 22;
	localparam int REM_W  = 9;

	localparam logic [JD_W-1:0] PERSIAN_ZERO = 22'd1947954;
	localparam logic [JD_W-1:0] GREG_EPOCH   = 22'd1721060;

	localparam logic [YEAR_W-1:0] P_YEAR_MIN = 12'd1;
	localparam logic [YEAR_W-1:0] P_YEAR_MAX = 12'd2324;
	localparam logic [YEAR_W-1:0] G_YEAR_MIN = 12'd623;
	localparam logic [YEAR_W-1:0] G_YEAR_MAX = 12'd2945;

	// floor(x / 1250) = (x * 858994) >> 30, exact for x below 1.5e6
	localparam logic [19:0] P_DIV_MUL   = 20'd858994;
	localparam int          P_DIV_SHIFT = 30;
	// floor(y / 100) = (y * 5243) >> 19, exact for 12-bit y
	localparam logic [12:0] D100_MUL    = 13'd5243;
	localparam int          D100_SHIFT  = 19;
	// floor(x / 365) = (x * 1470880) >> 29, exact for x below 1.8e6
	localparam logic [20:0] D365_MUL    = 21'd1470880;
	localparam int          D365_SHIFT  = 29;

	// Persian year offset: delta of the segment holding the year
	function automatic logic [10:0] seg_delta(input logic [YEAR_W-1:0] y);
		logic [10:0] r;
		priority if (y < 12'd6)    r = 11'd1249;
		else if (y < 12'd394)      r = 11'd952;
		else if (y < 12'd720)      r = 11'd891;
		else if (y < 12'd786)      r = 11'd930;
		else if (y < 12'd1145)     r = 11'd866;
		else if (y < 12'd1635)     r = 11'd869;
		else if (y < 12'd1701)     r = 11'd844;
		else if (y < 12'd1866)     r = 11'd848;
		else                       r = 11'd852;
		return r;
	endfunction

	// days in the Persian year before month m
	function automatic logic [REM_W-1:0] cum_pers(input logic [3:0] m);
		logic [REM_W-1:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd62;
			4'd4:    r = 9'd93;
			4'd5:    r = 9'd124;
			4'd6:    r = 9'd155;
			4'd7:    r = 9'd186;
			4'd8:    r = 9'd216;
			4'd9:    r = 9'd246;
			4'd10:   r = 9'd276;
			4'd11:   r = 9'd306;
			4'd12:   r = 9'd336;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// days in a common Gregorian year before month m
	function automatic logic [REM_W-1:0] cum_greg(input logic [3:0] m);
		logic [REM_W-1:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// days before month m in either calendar, leap day after February in the Gregorian one
	function automatic logic [REM_W-1:0] cum_days(input cal_t cal, input logic leap,
			input logic [3:0] m);
		logic [REM_W-1:0] r;
		if (cal == CAL_PERS) begin
			r = cum_pers(m);
		end else begin
			r = cum_greg(m) + REM_W'(leap && (m >= 4'd3));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/gpd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_in_if / gpd_out_if: item channels
// Valid/ready channels carrying a source date in and a converted date out.
// ----------------------------------------------------------------------------
interface gpd_in_if;
	logic        valid;
	logic        ready;
	logic        source_calendar;
	logic [11:0] in_year;
	logic [3:0]  in_month;
	logic [4:0]  in_day;

	modport source(output valid, source_calendar, in_year, in_month, in_day,
		input ready);
	modport sink(input valid, source_calendar, in_year, in_month, in_day,
		output ready);
endinterface

interface gpd_out_if;
	logic        valid;
	logic        ready;
	logic        date_valid;
	logic [11:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [2:0]  weekday;
	logic [21:0] day_number;

	modport source(output valid, date_valid, out_year, out_month, out_day, weekday,
		day_number, input ready);
	modport sink(input valid, date_valid, out_year, out_month, out_day, weekday,
		day_number, output ready);
endinterface

`default_nettype wire

// ----- sv/gregorian_persian_date_converter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_persian_date_converter: date conversion pipeline
// Converts a Gregorian or Persian date to the other calendar, with day
// number and weekday; invalid dates give an all-zero result.
// ----------------------------------------------------------------------------
// An eight-stage pipeline: an item enters in any cycle in which req.ready is
// high and moves through the stages in order to rsp; while rsp.ready stays
// high, the sustained rate is one item per cycle. Each stage holds its item
// until the next stage is free, so a stall on rsp fills the empty stages
// first and only then drops req.ready; no item is lost or repeated. The depth
// is set by the chained multiplies of the year start unit, used once for the
// source year and the year after it and once for the candidate years.
module gregorian_persian_date_converter
	import gpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	gpd_in_if.sink    req,
	gpd_out_if.source rsp
);

	localparam int NSTG = 8;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;

	logic            valid_s3;
	cal_t            cal_s3;
	logic [JD_W-1:0] jd_s3;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		en[NSTG] = !vld_q[NSTG] || rsp.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= req.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign req.ready = en[1];
	assign rsp.valid = vld_q[NSTG];

	gpd_to_days u_to_days (
		.clk      (clk),
		.en       (en[3:1]),
		.cal      (cal_t'(req.source_calendar)),
		.year     (req.in_year),
		.month    (req.in_month),
		.day      (req.in_day),
		.valid_s3 (valid_s3),
		.cal_s3   (cal_s3),
		.jd_s3    (jd_s3)
	);

	gpd_from_days u_from_days (
		.clk           (clk),
		.en            (en[8:4]),
		.valid         (valid_s3),
		.cal           (cal_s3),
		.jd            (jd_s3),
		.date_valid_s8 (rsp.date_valid),
		.year_s8       (rsp.out_year),
		.month_s8      (rsp.out_month),
		.day_s8        (rsp.out_day),
		.wd_s8         (rsp.weekday),
		.jd_s8         (rsp.day_number)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.date_valid |-> (rsp.out_year == 12'd0) &&
		(rsp.out_month == 4'd0) && (rsp.out_day == 5'd0) && (rsp.weekday == 3'd0) &&
		(rsp.day_number == 22'd0))
		else $error("invalid date with nonzero result fields");

	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.date_valid |-> (rsp.out_month >= 4'd1) &&
		(rsp.out_month <= 4'd12) && (rsp.out_day >= 5'd1) && (rsp.weekday != 3'd0))
		else $error("converted date fields out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_q[1])
		else $error("accepted item missing from first stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (vld_q == {NSTG{1'b1}}) && !rsp.ready)
		else $error("input stalled while a stage is empty");

endmodule

`default_nettype wire

// ----- sv/gpd_ystart.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_ystart: year start unit
// Two-stage pipeline giving the first day number of a year in either
// calendar, and the Gregorian leap flag (false outside 623..2945).
// ----------------------------------------------------------------------------
module gpd_ystart
	import gpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en_a,
	input  wire logic              en_b,
	input  wire cal_t              cal,
	input  wire logic [YEAR_W-1:0] year,
	output logic      [JD_W-1:0]   start,
	output logic                   leap
);

	logic [20:0]       x_d;
	logic [24:0]       p100;
	logic [20:0]       x_s1;
	logic [5:0]        q100_s1;
	logic [YEAR_W-1:0] year_s1;
	cal_t              cal_s1;

	logic [40:0]       p1250;
	logic [10:0]       q1250;
	logic [JD_W-1:0]   pstart;
	logic [JD_W-1:0]   gstart;
	logic              mod100_zero;
	logic              gleap;

	assign x_d  = 21'(seg_delta(year)) + 21'(year) * 21'd303;
	assign p100 = 25'(year) * 25'(D100_MUL);

	always_ff @(posedge clk) begin
		if (en_a) begin
			x_s1    <= x_d;
			q100_s1 <= p100[D100_SHIFT +: 6];
			year_s1 <= year;
			cal_s1  <= cal;
		end
	end

	always_comb begin
		p1250       = 41'(x_s1) * 41'(P_DIV_MUL);
		q1250       = p1250[P_DIV_SHIFT +: 11];
		pstart      = PERSIAN_ZERO + 22'(year_s1) * 22'd365 + 22'(q1250) + 22'd1;
		mod100_zero = (year_s1 == 12'(12'(q100_s1) * 12'd100));
		gleap       = (year_s1 >= G_YEAR_MIN) && (year_s1 <= G_YEAR_MAX) &&
			(year_s1[1:0] == 2'b00) && (!mod100_zero || (q100_s1[1:0] == 2'b00));
		gstart      = 22'(year_s1) * 22'd365 + 22'(year_s1[11:2]) - 22'(q100_s1) +
			22'(q100_s1[5:2]) - 22'(gleap) + GREG_EPOCH + 22'd1;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			start <= (cal_s1 == CAL_PERS) ? pstart : gstart;
			leap  <= gleap;
		end
	end

endmodule

`default_nettype wire

// ----- sv/gpd_to_days.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_to_days: validation and day number
// Stages 1 to 3: range checks, year starts, month length check and the
// absolute day number of the source date.
// ----------------------------------------------------------------------------
module gpd_to_days
	import gpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [2:0]        en,
	input  wire cal_t              cal,
	input  wire logic [YEAR_W-1:0] year,
	input  wire logic [3:0]        month,
	input  wire logic [4:0]        day,
	output logic                   valid_s3,
	output cal_t                   cal_s3,
	output logic      [JD_W-1:0]   jd_s3
);

	logic              ok_d;
	logic              ok_s1, ok_s2;
	cal_t              cal_s1, cal_s2;
	logic [3:0]        month_s1, month_s2;
	logic [4:0]        day_s1, day_s2;
	logic [JD_W-1:0]   start0, start1;
	logic              leap0, leap1;
	logic [JD_W-1:0]   plen;
	logic [4:0]        lim;
	logic [JD_W-1:0]   jd_d;

	always_comb begin
		ok_d = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1);
		if (cal == CAL_PERS) begin
			ok_d = ok_d && (year >= P_YEAR_MIN) && (year <= P_YEAR_MAX);
		end else begin
			ok_d = ok_d && (year >= G_YEAR_MIN) && (year <= G_YEAR_MAX);
		end
	end

	gpd_ystart u_ys_cur (
		.clk   (clk),
		.en_a  (en[0]),
		.en_b  (en[1]),
		.cal   (cal),
		.year  (year),
		.start (start0),
		.leap  (leap0)
	);

	gpd_ystart u_ys_next (
		.clk   (clk),
		.en_a  (en[0]),
		.en_b  (en[1]),
		.cal   (cal),
		.year  (year + 12'd1),
		.start (start1),
		.leap  (leap1)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ok_s1    <= ok_d;
			cal_s1   <= cal;
			month_s1 <= month;
			day_s1   <= day;
		end
		if (en[1]) begin
			ok_s2    <= ok_s1;
			cal_s2   <= cal_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
		end
	end

	always_comb begin
		plen = start1 - start0;
		if (cal_s2 == CAL_PERS) begin
			if (month_s2 == 4'd12) begin
				lim = (plen == 22'd366) ? 5'd30 : 5'd29;
			end else begin
				lim = (month_s2 <= 4'd6) ? 5'd31 : 5'd30;
			end
		end else begin
			if (month_s2 == 4'd2) begin
				lim = leap0 ? 5'd29 : 5'd28;
			end else if ((month_s2 == 4'd4) || (month_s2 == 4'd6) ||
					(month_s2 == 4'd9) || (month_s2 == 4'd11)) begin
				lim = 5'd30;
			end else begin
				lim = 5'd31;
			end
		end
		jd_d = start0 + 22'(cum_days(cal_s2, leap0, month_s2)) + 22'(day_s2) - 22'd1;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			valid_s3 <= ok_s2 && (day_s2 <= lim);
			cal_s3   <= cal_s2;
			jd_s3    <= jd_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/gpd_from_days.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_from_days: year and month search
// Stages 4 to 8: year estimate, four candidate year starts, candidate
// pick, month split and weekday.
// ----------------------------------------------------------------------------
module gpd_from_days
	import gpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [4:0]        en,
	input  wire logic              valid,
	input  wire cal_t              cal,
	input  wire logic [JD_W-1:0]   jd,
	output logic                   date_valid_s8,
	output logic      [YEAR_W-1:0] year_s8,
	output logic      [3:0]        month_s8,
	output logic      [4:0]        day_s8,
	output logic      [2:0]        wd_s8,
	output logic      [JD_W-1:0]   jd_s8
);

	localparam int NCAND = 4;

	cal_t              ocal_d;
	logic [JD_W-1:0]   base;
	logic [20:0]       diff;
	logic [41:0]       p365;
	logic [23:0]       jd_pad;
	logic [5:0]        oct_sum;
	logic [3:0]        fold1, fold2, wd_tmp;
	logic [2:0]        wd_d;

	logic              valid_s4, valid_s5, valid_s6, valid_s7;
	cal_t              ocal_s4, ocal_s5, ocal_s6, ocal_s7;
	logic [JD_W-1:0]   jd_s4, jd_s5, jd_s6, jd_s7;
	logic [2:0]        wd_s4, wd_s5, wd_s6, wd_s7;
	logic [YEAR_W-1:0] est_s4, est_s5, est_s6;

	logic [JD_W-1:0]   cstart [NCAND];
	logic              cleap  [NCAND];

	logic [1:0]        pick;
	logic [JD_W-1:0]   pstart;
	logic              pleap;
	logic [YEAR_W-1:0] year_s7;
	logic [REM_W-1:0]  rem_s7;
	logic              leap_s7;

	logic [3:0]        mcnt;
	logic [3:0]        mon_d;
	logic [REM_W-1:0]  day_d;

	// year estimate and weekday
	always_comb begin
		ocal_d  = (cal == CAL_PERS) ? CAL_GREG : CAL_PERS;
		base    = (ocal_d == CAL_GREG) ? GREG_EPOCH : PERSIAN_ZERO;
		diff    = 21'(jd - base);
		p365    = 42'(diff) * 42'(D365_MUL);
		jd_pad  = {2'b00, jd};
		oct_sum = '0;
		for (int i = 0; i < 8; i++) begin
			oct_sum = oct_sum + 6'(jd_pad[3*i +: 3]);
		end
		fold1  = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
		fold2  = 4'(fold1[3]) + 4'(fold1[2:0]);
		wd_tmp = (fold2 >= 4'd7) ? fold2 - 4'd7 : fold2;
		wd_tmp = wd_tmp + 4'd3;
		wd_d   = (wd_tmp > 4'd7) ? 3'(wd_tmp - 4'd7) : 3'(wd_tmp);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			valid_s4 <= valid;
			ocal_s4  <= ocal_d;
			jd_s4    <= jd;
			wd_s4    <= wd_d;
			est_s4   <= p365[D365_SHIFT +: YEAR_W];
		end
		if (en[1]) begin
			valid_s5 <= valid_s4;
			ocal_s5  <= ocal_s4;
			jd_s5    <= jd_s4;
			wd_s5    <= wd_s4;
			est_s5   <= est_s4;
		end
		if (en[2]) begin
			valid_s6 <= valid_s5;
			ocal_s6  <= ocal_s5;
			jd_s6    <= jd_s5;
			wd_s6    <= wd_s5;
			est_s6   <= est_s5;
		end
	end

	// the true year lies within three below the estimate
	for (genvar c = 0; c < NCAND; c++) begin : g_cand
		gpd_ystart u_ys (
			.clk   (clk),
			.en_a  (en[1]),
			.en_b  (en[2]),
			.cal   (ocal_s4),
			.year  (est_s4 - 12'(NCAND - 1 - c)),
			.start (cstart[c]),
			.leap  (cleap[c])
		);
	end

	// take the latest candidate that starts on or before the day
	always_comb begin
		priority if (cstart[3] <= jd_s6) pick = 2'd3;
		else if (cstart[2] <= jd_s6)     pick = 2'd2;
		else if (cstart[1] <= jd_s6)     pick = 2'd1;
		else                             pick = 2'd0;
		unique case (pick)
			2'd3:    begin pstart = cstart[3]; pleap = cleap[3]; end
			2'd2:    begin pstart = cstart[2]; pleap = cleap[2]; end
			2'd1:    begin pstart = cstart[1]; pleap = cleap[1]; end
			default: begin pstart = cstart[0]; pleap = cleap[0]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			valid_s7 <= valid_s6;
			ocal_s7  <= ocal_s6;
			jd_s7    <= jd_s6;
			wd_s7    <= wd_s6;
			year_s7  <= est_s6 - 12'(NCAND - 1) + 12'(pick);
			rem_s7   <= REM_W'(jd_s6 - pstart);
			leap_s7  <= pleap;
		end
	end

	// month is one plus the number of later month starts already passed
	always_comb begin
		mcnt = '0;
		for (int i = 2; i <= 12; i++) begin
			mcnt = mcnt + 4'(rem_s7 >= cum_days(ocal_s7, leap_s7, 4'(i)));
		end
		mon_d = mcnt + 4'd1;
		day_d = rem_s7 - cum_days(ocal_s7, leap_s7, mon_d) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			date_valid_s8 <= valid_s7;
			year_s8       <= valid_s7 ? year_s7 : '0;
			month_s8      <= valid_s7 ? mon_d : '0;
			day_s8        <= valid_s7 ? day_d[4:0] : '0;
			wd_s8         <= valid_s7 ? wd_s7 : '0;
			jd_s8         <= valid_s7 ? jd_s7 : '0;
		end
	end

endmodule

`default_nettype wire

// ----- test/tb_gregorian_persian_date_converter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_gregorian_persian_date_converter: self-checking testbench
// Drives Gregorian and Persian dates into the converter with random gaps
// and output stalls. An internal calendar predictor computes each result
// and the checker compares every output item in order, all fields at once.
// ----------------------------------------------------------------------------
module tb_gregorian_persian_date_converter;
	import gpd_pkg::*;

	typedef struct packed {
		logic        date_valid;
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  weekday;
		logic [21:0] day_number;
	} conv_result_t;

	logic clk;
	logic arst_n;

	gpd_in_if  req();
	gpd_out_if rsp();

	gregorian_persian_date_converter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	conv_result_t expected_dates[$];
	int           mismatches;
	int           sent_items;
	bit           send_gaps;
	bit           recv_gaps;
	int           rsp_hold;
	bit           rsp_taken;

	const longint SEG_BREAK[9] = '{6, 394, 720, 786, 1145, 1635, 1701, 1866, 2328};
	const longint SEG_DELTA[9] = '{1249, 952, 891, 930, 866, 869, 844, 848, 852};
	const longint GREG_LEN[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	const longint PERS_LEN[11] = '{31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 30};

	// ------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------
	function automatic longint pers_year_start(longint y);
		int k;
		k = 8;
		for (int i = 8; i >= 0; i--)
			if (y < SEG_BREAK[i])
				k = i;
		return 1947954 + y * 365 + (SEG_DELTA[k] + y * 303) / 1250;
	endfunction

	// leap only inside the supported Gregorian range
	function automatic bit greg_is_leap(longint y);
		if (y < 623 || y > 2945)
			return 1'b0;
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint greg_year_start(longint y);
		longint r;
		r = y * 365 + y / 4 - y / 100 + y / 400;
		if (greg_is_leap(y))
			r--;
		return r + 1721060 + 1;
	endfunction

	function automatic longint greg_month_days(longint y, int m0);
		if (m0 == 1)
			return greg_is_leap(y) ? 29 : 28;
		return GREG_LEN[m0];
	endfunction

	function automatic conv_result_t predict_result(cal_t cal, logic [11:0] yin,
			logic [3:0] m, logic [4:0] d);
		conv_result_t res;
		longint y, lim, jd, yr, s0, s1, rem, len, wd;
		bit pers, done;
		res  = '0;
		y    = yin;
		pers = (cal == CAL_PERS);
		if (m < 1 || m > 12 || d < 1)
			return res;
		if (pers) begin
			if (y < 1 || y > 2324)
				return res;
			if (m == 12)
				lim = (pers_year_start(y + 1) - pers_year_start(y) == 366) ? 30 : 29;
			else
				lim = PERS_LEN[m - 1];
		end else begin
			if (y < 623 || y > 2945)
				return res;
			lim = greg_month_days(y, m - 1);
		end
		if (d > lim)
			return res;
		// absolute day number of the source date
		if (pers) begin
			jd = pers_year_start(y) + 1;
			for (int i = 0; i < m - 1; i++)
				jd += PERS_LEN[i];
		end else begin
			jd = greg_year_start(y);
			for (int i = 0; i < m - 1; i++)
				jd += greg_month_days(y, i);
		end
		jd = jd + d - 1;
		// search the other calendar for the year holding jd
		yr = pers ? (jd - 1721060) / 365 : (jd - 1947954) / 365;
		s0 = 0;
		for (int it = 0; it < 16; it++) begin
			if (!pers) begin
				s0 = pers_year_start(yr) + 1;
				s1 = pers_year_start(yr + 1) + 1;
			end else begin
				s0 = greg_year_start(yr);
				s1 = s0 + (greg_is_leap(yr) ? 366 : 365);
			end
			if (s0 > jd)
				yr--;
			else if (s1 <= jd)
				yr++;
			else
				break;
		end
		rem  = jd - s0;
		done = 1'b0;
		res.out_year = yr[11:0];
		for (int i = 0; i < 11 && !done; i++) begin
			len = pers ? greg_month_days(yr, i) : PERS_LEN[i];
			if (rem < len) begin
				res.out_month = 4'(i + 1);
				res.out_day   = 5'(rem + 1);
				done = 1'b1;
			end else begin
				rem -= len;
			end
		end
		// last month takes whatever is left of the year
		if (!done) begin
			res.out_month = 4'd12;
			res.out_day   = 5'(rem + 1);
		end
		wd = jd % 7 + 3;
		if (wd > 7)
			wd -= 7;
		res.date_valid = 1'b1;
		res.weekday    = 3'(wd);
		res.day_number = jd[21:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// clock, reset, timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** gregorian_persian_date_converter: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// output side: ready with random stalls, checker at the rising edge
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		rsp.ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rsp_taken) begin
				stall_left = recv_gaps ? $urandom_range(0, 17) : 0;
				rsp_taken  = 1'b0;
			end
			if (rsp_hold > 0) begin
				rsp.ready = 1'b0;
				rsp_hold--;
			end else if (stall_left > 0) begin
				rsp.ready = 1'b0;
				stall_left--;
			end else begin
				rsp.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		conv_result_t got, exp_res;
		if (arst_n && rsp.valid && rsp.ready) begin
			rsp_taken = 1'b1;
			got = {rsp.date_valid, rsp.out_year, rsp.out_month, rsp.out_day,
				rsp.weekday, rsp.day_number};
			if (expected_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output item %p", got);
			end else begin
				exp_res = expected_dates.pop_front();
				if (got !== exp_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_res, got);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	task automatic send_date(cal_t cal, logic [11:0] y, logic [3:0] m, logic [4:0] d);
		int gap;
		gap = send_gaps ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.source_calendar = cal;
		req.in_year         = y;
		req.in_month        = m;
		req.in_day          = d;
		req.valid           = 1'b1;
		do @(posedge clk); while (!req.ready);
		expected_dates.push_back(predict_result(cal, y, m, d));
		sent_items++;
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		// drop valid so the last item is not offered again
		@(negedge clk);
		req.valid = 1'b0;
		while (expected_dates.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic send_random_date();
		cal_t cal;
		int   y;
		int   pick;
		cal  = cal_t'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// noise across the whole field ranges
			send_date(cal, 12'($urandom), 4'($urandom), 5'($urandom));
		end else begin
			if (pick < 20)
				y = (cal == CAL_PERS) ? $urandom_range(0, 5) + ($urandom_range(0, 1) ? 2320 : 0)
					: $urandom_range(0, 5) + ($urandom_range(0, 1) ? 2941 : 620);
			else
				y = (cal == CAL_PERS) ? $urandom_range(1, 2324) : $urandom_range(623, 2945);
			send_date(cal, 12'(y), 4'($urandom_range(1, 12)),
				5'($urandom_range(0, 3) == 0 ? $urandom_range(28, 31) : $urandom_range(1, 31)));
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_field_extremes();
		send_date(CAL_GREG, 12'd0, 4'd0, 5'd0);
		send_date(CAL_PERS, 12'd4095, 4'd15, 5'd31);
		send_date(CAL_GREG, 12'd2000, 4'd0, 5'd1);
		send_date(CAL_GREG, 12'd2000, 4'd13, 5'd1);
		send_date(CAL_PERS, 12'd1400, 4'd5, 5'd0);
		send_date(CAL_GREG, 12'd4095, 4'd1, 5'd1);
	endtask

	task automatic test_year_limits();
		send_date(CAL_GREG, 12'd622, 4'd12, 5'd31);
		send_date(CAL_GREG, 12'd623, 4'd1, 5'd1);
		send_date(CAL_GREG, 12'd2945, 4'd12, 5'd31);
		send_date(CAL_GREG, 12'd2946, 4'd1, 5'd1);
		send_date(CAL_PERS, 12'd0, 4'd1, 5'd1);
		send_date(CAL_PERS, 12'd1, 4'd1, 5'd1);
		send_date(CAL_PERS, 12'd2324, 4'd12, 5'd29);
		send_date(CAL_PERS, 12'd2325, 4'd1, 5'd1);
		// a table segment edge and the year below the upper Persian limit
		send_date(CAL_PERS, 12'd1865, 4'd12, 5'd29);
		send_date(CAL_PERS, 12'd2323, 4'd12, 5'd30);
	endtask

	task automatic test_month_ends();
		send_date(CAL_GREG, 12'd2000, 4'd2, 5'd29);
		send_date(CAL_GREG, 12'd1900, 4'd2, 5'd29);
		send_date(CAL_GREG, 12'd2024, 4'd2, 5'd30);
		send_date(CAL_GREG, 12'd2023, 4'd4, 5'd31);
		send_date(CAL_PERS, 12'd1403, 4'd12, 5'd30);
		send_date(CAL_PERS, 12'd1402, 4'd12, 5'd30);
		send_date(CAL_PERS, 12'd1402, 4'd7, 5'd31);
		send_date(CAL_PERS, 12'd1399, 4'd12, 5'd30);
	endtask

	task automatic test_random_dates(int count);
		for (int i = 0; i < count; i++) begin
			// stretches with and without idling, chosen at random
			if (i % 200 == 0) begin
				send_gaps = $urandom_range(0, 3) != 0;
				recv_gaps = $urandom_range(0, 3) != 0;
			end
			send_random_date();
		end
	endtask

	task automatic test_backpressure();
		send_gaps = 1'b0;
		rsp_hold  = 80;
		for (int i = 0; i < 40; i++)
			send_random_date();
		send_gaps = 1'b1;
	endtask

	task automatic test_drain_pause();
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_random_date();
	endtask

	initial begin
		arst_n              = 1'b0;
		req.valid           = 1'b0;
		req.source_calendar = 1'b0;
		req.in_year         = '0;
		req.in_month        = '0;
		req.in_day          = '0;
		mismatches          = 0;
		sent_items          = 0;
		send_gaps           = 1'b1;
		recv_gaps           = 1'b1;
		rsp_hold            = 0;
		rsp_taken           = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_year_limits();
		test_month_ends();
		test_backpressure();
		test_random_dates(900);
		test_drain_pause();
		test_random_dates(800);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_dates.size() == 0) begin
			$display("** gregorian_persian_date_converter: PASSED **");
		end else begin
			$display("** gregorian_persian_date_converter: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/gpd_pkg.sv
sv/gpd_if.sv
sv/gpd_ystart.sv
sv/gpd_to_days.sv
sv/gpd_from_days.sv
sv/gregorian_persian_date_converter.sv
test/tb_gregorian_persian_date_converter.sv
